// File: rtl/srsu_pkg.sv
// ----------------------------------------------------------------------------
// srsu_pkg
// Shared types and field layout for the stepping rotor substitution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srsu_pkg;

   localparam int ALPHABET_SIZE_DEFAULT = 256;
   localparam int SYM_W                 = 8;
   localparam int ENTRY_W               = 2 * SYM_W;

   // request tdata layout, lowest bit first
   localparam int LETTER_LSB   = 0;
   localparam int DIR_LSB      = LETTER_LSB + SYM_W;
   localparam int ROW_LSB      = DIR_LSB + 1;
   localparam int LEFT_LSB     = ROW_LSB + SYM_W;
   localparam int RIGHT_LSB    = LEFT_LSB + SYM_W;
   localparam int REQ_FIELDS_W = RIGHT_LSB + SYM_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = SYM_W;
   localparam int RSP_TUSER_W  = 1;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_DECODE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_REDUCE,
      ST_FINAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [SYM_W-1:0] letter;
      logic             direction;
      logic [SYM_W-1:0] row_index;
      logic [SYM_W-1:0] left_value;
      logic [SYM_W-1:0] right_value;
   } req_item_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol_out;
      logic             match_found;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: rtl/stepping_rotor_substitution_unit.sv
// ----------------------------------------------------------------------------
// stepping_rotor_substitution_unit
// Rotor substitution stage with a loadable wiring table and stepping
// encode and decode positions.
//
// The req channel carries one item per transfer: tuser selects load, encode
// or decode, tdata holds the letter, direction, row and the two row entries.
// A load writes one table row in its accept cycle and gives no result. An
// encode or decode gives one rsp transfer: tdata is the symbol, tuser flags a
// match. Every row must be loaded before the first lookup.
// A lookup scans the table from row ALPHABET_SIZE-1 down and stops at the
// first match, one row per cycle through the single read port of the table
// memory. An encode steps through ST_PREP, ST_SCAN and ST_DONE; a decode
// that finds a match also passes ST_REDUCE and ST_FINAL before ST_DONE.
// The next item is taken once the result moves to the output register.
// Reset clears both positions and the channel state; table contents are kept
// undefined until loaded. While rsp_tready is low, one result waits in the
// output register and a second one holds inside the block, which then takes
// no further items.
// ----------------------------------------------------------------------------
`default_nettype none

module stepping_rotor_substitution_unit
   import srsu_pkg::*;
#(
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // letter, direction, row_index, left_value, right_value, zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // symbol_out
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   // match_found
   output logic      [RSP_TUSER_W-1:0] rsp_tuser
);

   req_item_type req_item;
   rsp_item_type res_item;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic         res_valid;
   logic         res_ready;

   assign req_item = '{
      opcode:      opcode_type'(req_tuser),
      letter:      req_tdata[LETTER_LSB +: SYM_W],
      direction:   req_tdata[DIR_LSB],
      row_index:   req_tdata[ROW_LSB +: SYM_W],
      left_value:  req_tdata[LEFT_LSB +: SYM_W],
      right_value: req_tdata[RIGHT_LSB +: SYM_W]
   };

   srsu_engine #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_item  (res_item)
   );

   // load the output register when empty or draining
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_item_in   = rsp_item_ff;
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_item_in   = res_item;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_item_ff.symbol_out;
   assign rsp_tuser  = rsp_item_ff.match_found;

endmodule

`default_nettype wire

// File: rtl/srsu_ram.sv
// ----------------------------------------------------------------------------
// srsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srsu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/srsu_engine.sv
// ----------------------------------------------------------------------------
// srsu_engine
// Wiring table memory, rotor positions and the lookup sequencer. A lookup
// scans the table from the highest row down and stops at the first match.
// ----------------------------------------------------------------------------
`default_nettype none

module srsu_engine
   import srsu_pkg::*;
#(
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              res_valid,
   input  wire logic         res_ready,
   output rsp_item_type      res_item
);

   localparam int POS_W       = $clog2(ALPHABET_SIZE);
   localparam int VAL_W       = POS_W + 2;
   localparam int RECIP_SHIFT = 2 * SYM_W;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + ALPHABET_SIZE - 1) / ALPHABET_SIZE;

   state_type state_ff, state_in;

   req_item_type              item_ff, item_in;
   logic [POS_W-1:0]          enc_pos_ff, enc_pos_in;
   logic [POS_W-1:0]          dec_pos_ff, dec_pos_in;
   logic [SYM_W-1:0]          key_ff, key_in;
   logic [POS_W-1:0]          row_ff, row_in;
   logic [SYM_W-1:0]          entry_ff, entry_in;
   logic [POS_W-1:0]          red_ff, red_in;
   rsp_item_type              res_ff, res_in;

   logic                      accept;
   logic                      is_decode;
   logic                      mem_wr_en;
   logic [POS_W-1:0]          rd_addr;
   logic [ENTRY_W-1:0]        rd_data;
   logic [SYM_W-1:0]          match_col;
   logic [SYM_W-1:0]          ret_col;
   logic                      hit;
   logic [SYM_W-1:0]          red_src;
   logic [3*SYM_W-1:0]        red_prod;
   logic [SYM_W-1:0]          red_quot;
   logic [2*SYM_W:0]          red_back;
   logic [SYM_W:0]            red_full;
   logic [POS_W-1:0]          red_val;
   logic [POS_W:0]            enc_sum;
   logic [POS_W:0]            enc_key;
   logic [VAL_W-1:0]          off_plus1;
   logic [VAL_W-1:0]          dec_val;
   logic [VAL_W-1:0]          dec_sym;

   assign accept    = req_valid && req_ready;
   assign is_decode = (item_ff.opcode == OP_DECODE);
   assign mem_wr_en = accept && (req_item.opcode == OP_LOAD)
                      && ({1'b0, req_item.row_index} < (SYM_W+1)'(ALPHABET_SIZE));

   srsu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_item.row_index[POS_W-1:0]),
      .wr_data ({req_item.right_value, req_item.left_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // direction 0 matches the right column and returns the left one
   assign match_col = item_ff.direction ? rd_data[SYM_W-1:0] : rd_data[ENTRY_W-1:SYM_W];
   assign ret_col   = item_ff.direction ? rd_data[ENTRY_W-1:SYM_W] : rd_data[SYM_W-1:0];
   assign hit       = (match_col == key_ff);

   // remainder by the alphabet size through a reciprocal multiply
   assign red_src  = (state_ff == ST_PREP) ? item_ff.letter : entry_ff;
   assign red_prod = (3*SYM_W)'(red_src) * (3*SYM_W)'(RECIP);
   assign red_quot = red_prod[3*SYM_W-1:RECIP_SHIFT];
   assign red_back = (2*SYM_W+1)'(red_quot) * (2*SYM_W+1)'(ALPHABET_SIZE);
   assign red_full = {1'b0, red_src} - red_back[SYM_W:0];
   assign red_val  = red_full[POS_W-1:0];

   assign enc_sum = {1'b0, red_val} + {1'b0, enc_pos_ff};
   assign enc_key = (enc_sum >= (POS_W+1)'(ALPHABET_SIZE))
                    ? enc_sum - (POS_W+1)'(ALPHABET_SIZE) : enc_sum;

   assign off_plus1 = item_ff.direction ? VAL_W'(dec_pos_ff)
                                        : VAL_W'(dec_pos_ff) + VAL_W'(2);
   assign dec_val   = VAL_W'(red_ff) + VAL_W'(ALPHABET_SIZE) + VAL_W'(1) - off_plus1;
   assign dec_sym   = (dec_val >= VAL_W'(2 * ALPHABET_SIZE))
                      ? dec_val - VAL_W'(2 * ALPHABET_SIZE)
                      : (dec_val >= VAL_W'(ALPHABET_SIZE))
                        ? dec_val - VAL_W'(ALPHABET_SIZE) : dec_val;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.opcode == OP_ENCODE || req_item.opcode == OP_DECODE)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = is_decode ? ST_REDUCE : ST_DONE;
            end else if (row_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_REDUCE: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      res_valid = (state_ff == ST_DONE);
      res_item  = res_ff;
      rd_addr   = (state_ff == ST_PREP) ? POS_W'(ALPHABET_SIZE - 1) : row_ff - POS_W'(1);
   end

   always_comb begin
      item_in    = accept ? req_item : item_ff;
      enc_pos_in = enc_pos_ff;
      dec_pos_in = dec_pos_ff;
      if (accept && req_item.opcode == OP_ENCODE) begin
         enc_pos_in = (enc_pos_ff == POS_W'(ALPHABET_SIZE - 1)) ? '0 : enc_pos_ff + POS_W'(1);
      end
      if (accept && req_item.opcode == OP_DECODE) begin
         dec_pos_in = (dec_pos_ff == POS_W'(ALPHABET_SIZE - 1)) ? '0 : dec_pos_ff + POS_W'(1);
      end
      key_in   = key_ff;
      row_in   = row_ff;
      entry_in = entry_ff;
      red_in   = red_ff;
      res_in   = res_ff;
      if (state_ff == ST_PREP) begin
         key_in = is_decode ? item_ff.letter : SYM_W'(enc_key);
      end
      if (state_ff == ST_PREP || state_ff == ST_SCAN) begin
         row_in = rd_addr;
      end
      if (state_ff == ST_SCAN) begin
         entry_in = ret_col;
         if (hit) begin
            res_in = '{symbol_out: ret_col, match_found: 1'b1};
         end else begin
            res_in = '{symbol_out: '0, match_found: 1'b0};
         end
      end
      if (state_ff == ST_REDUCE) begin
         red_in = red_val;
      end
      if (state_ff == ST_FINAL) begin
         res_in = '{symbol_out: SYM_W'(dec_sym[POS_W-1:0]), match_found: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         enc_pos_ff <= '0;
         dec_pos_ff <= '0;
      end else begin
         state_ff   <= state_in;
         enc_pos_ff <= enc_pos_in;
         dec_pos_ff <= dec_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      key_ff   <= key_in;
      row_ff   <= row_in;
      entry_ff <= entry_in;
      red_ff   <= red_in;
      res_ff   <= res_in;
   end

endmodule

`default_nettype wire
